### hw/rtl/acm_pkg.sv
// ============================================================================
// acm_pkg - shared types, constants and AES helper functions
// Holds the S-box, round helpers and the queue entry type for the CBC-MAC unit.
// ============================================================================
`default_nettype none
package acm_pkg;

    localparam int unsigned BLK_W     = 128;
    localparam int unsigned HALF_W    = 64;
    localparam int unsigned N_ROUNDS  = 10;
    localparam int unsigned RND_W     = 4;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // configuration register indexes
    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW  = 1'b1;
    localparam int unsigned CFG_IDX_W   = 1;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic             last;
    } t_q_entry;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the state sits in bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input logic [BLK_W-1:0] s, input int i);
        return s[BLK_W-1-8*i -: 8];
    endfunction

    // rcon for round r (1..10)
    function automatic logic [7:0] rcon(input logic [RND_W-1:0] r);
        logic [7:0] v;
        v = 8'h01;
        for (int k = 1; k < 10; k++) begin
            if (k < int'(r)) v = xtime(v);
        end
        return v;
    endfunction

    // next round key from the previous one
    function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] k,
                                                  input logic [RND_W-1:0] r);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {sbox(k[23:16]) ^ rcon(r), sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
        w0 = k[127:96] ^ t;
        w1 = k[95:64]  ^ w0;
        w2 = k[63:32]  ^ w1;
        w3 = k[31:0]   ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // one round without the round key; last drops MixColumns
    function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                   input logic lastr);
        logic [7:0] n [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [BLK_W-1:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                n[r+4*c] = sbox(get_byte(s, r + 4*((c + r) & 3)));
        for (int c = 0; c < 4; c++) begin
            a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (!lastr) begin
                o[BLK_W-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
                o[BLK_W-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
                o[BLK_W-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
                o[BLK_W-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
            end else begin
                o[BLK_W-1-8*(4*c)   -: 8] = a0;
                o[BLK_W-1-8*(4*c+1) -: 8] = a1;
                o[BLK_W-1-8*(4*c+2) -: 8] = a2;
                o[BLK_W-1-8*(4*c+3) -: 8] = a3;
            end
        end
        return o;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/acm_front.sv
// ============================================================================
// acm_front - input side and block queue
// Takes message items and holds them in a small FIFO for the round engine.
// ============================================================================
`default_nettype none
module acm_front #(
    parameter int unsigned DEPTH = acm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire acm_pkg::t_q_entry   i_entry,
    output logic                     o_q_valid,
    input  wire                      i_q_pop,
    output acm_pkg::t_q_entry        o_q_entry
);
    import acm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_q_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;
    logic push;

    assign o_ready   = (r_cnt != PTR_W'(0) + (PTR_W+1)'(DEPTH)) ? 1'b1 : 1'b0;
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_entry = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push)    r_wr <= bump(r_wr);
            if (i_q_pop) r_rd <= bump(r_rd);
            r_cnt <= r_cnt + (push ? 1'b1 : 1'b0) - (i_q_pop ? 1'b1 : 1'b0);
        end
    end
endmodule
`default_nettype wire

### hw/rtl/acm_back.sv
// ============================================================================
// acm_back - iterative AES-128 round engine with chaining and MAC output
// One round per cycle, round keys expanded on the fly; result in an out register.
// ============================================================================
`default_nettype none
module acm_back (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire [acm_pkg::BLK_W-1:0]        i_key,
    input  wire                             i_q_valid,
    input  wire acm_pkg::t_q_entry          i_q_entry,
    output logic                            o_q_pop,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic [acm_pkg::BLK_W-1:0]       o_mac
);
    import acm_pkg::*;

    logic [BLK_W-1:0] r_state, r_rkey, r_chain;
    logic [RND_W-1:0] r_round;
    logic r_run, r_last, r_ovalid;
    logic [BLK_W-1:0] rk_next, st_next;
    logic done, fin, out_free;

    assign out_free = !r_ovalid || i_ready;
    // a finished last block holds in the engine while the out register is full
    assign fin      = done && (!r_last || out_free);
    assign o_q_pop  = i_q_valid && (!r_run || fin);
    assign rk_next  = key_step(r_rkey, r_round);
    assign st_next  = aes_round(r_state, r_round == RND_W'(N_ROUNDS)) ^ rk_next;
    assign done     = r_run && (r_round == RND_W'(N_ROUNDS));
    assign o_valid  = r_ovalid;

    // chaining value seen by a block that starts as the previous one finishes
    function automatic logic [BLK_W-1:0] chain_eff();
        if (done) return r_last ? '0 : st_next;
        return r_chain;
    endfunction

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_state <= (i_q_entry.blk ^ chain_eff()) ^ i_key;
            r_rkey  <= i_key;
            r_last  <= i_q_entry.last;
        end else if (r_run && !done) begin
            r_state <= st_next;
            r_rkey  <= rk_next;
        end
        if (fin && r_last) o_mac <= st_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_round  <= '0;
            r_chain  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (fin) r_chain <= r_last ? '0 : st_next;
            if (o_q_pop) begin
                r_run   <= 1'b1;
                r_round <= RND_W'(1);
            end else if (fin) begin
                r_run   <= 1'b0;
            end else if (r_run && !done) begin
                r_round <= r_round + 1'b1;
            end
            if (fin && r_last) r_ovalid <= 1'b1;
            else if (i_ready)  r_ovalid <= 1'b0;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/aes128_cbc_mac_unit.sv
// ============================================================================
// aes128_cbc_mac_unit - AES-128 CBC-MAC engine, zero IV
// Top level: config registers, input queue and the round engine.
// ============================================================================
// Each item is one 128-bit block; it is XORed into the chaining value and
// encrypted under the key held in the registers. An item with last_block set
// yields one MAC item and clears the chaining value. The round engine does one
// AES round per cycle with the key schedule run alongside: a load step adds
// the first round key and ten rounds follow, and a queued block loads on the
// edge of the previous block's last round, so the engine takes a new item as
// the previous one finishes. A MAC is offered at the earliest after its item
// passes the queue, load step, rounds and output register. A finished
// last block waits in the engine while an earlier MAC sits unread in the
// output register. The input side keeps taking items into a two-entry queue
// while the engine works or waits. Key writes apply to blocks started later.
`default_nettype none
module aes128_cbc_mac_unit #(
    parameter int unsigned QUEUE_DEPTH = acm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [acm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [acm_pkg::HALF_W-1:0]        i_cfg_data,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire [acm_pkg::HALF_W-1:0]        i_block_high,
    input  wire [acm_pkg::HALF_W-1:0]        i_block_low,
    input  wire                              i_last_block,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [acm_pkg::HALF_W-1:0]       o_mac_high,
    output logic [acm_pkg::HALF_W-1:0]       o_mac_low
);
    import acm_pkg::*;

    logic [HALF_W-1:0] r_key_high, r_key_low;
    t_q_entry in_entry, q_entry;
    logic q_valid, q_pop;
    logic [BLK_W-1:0] mac;

    assign o_cfg_ready = 1'b1;

    // key registers; index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_entry.blk  = {i_block_high, i_block_low};
    assign in_entry.last = i_last_block;

    acm_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n,
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_entry   (in_entry),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_entry (q_entry)
    );

    acm_back u_back (
        .i_clk, .i_rst_n,
        .i_key     ({r_key_high, r_key_low}),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_mac     (mac)
    );

    assign o_mac_high = mac[BLK_W-1:HALF_W];
    assign o_mac_low  = mac[HALF_W-1:0];
endmodule
`default_nettype wire

### hw/rtl/acm_checker.sv
// ============================================================================
// acm_checker - port-level checks for the CBC-MAC unit
// Handshake and output stability checks, bound to the top level.
// ============================================================================
`default_nettype none
module acm_checker (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          o_valid,
    input wire          i_ready,
    input wire [63:0]   o_mac_high,
    input wire [63:0]   o_mac_low,
    input wire          i_valid,
    input wire          o_ready,
    input wire          o_cfg_ready
);
    // a MAC item holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mac_high) && $stable(o_mac_low))
        else $error("MAC item dropped or changed while stalled");

    // no MAC right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("MAC item out of reset");

    // an offered input item stays offered while the block is full
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid)
        else $error("input item withdrawn before it was taken");

    // config port always open
    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port stalled");
endmodule

bind aes128_cbc_mac_unit acm_checker u_acm_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_mac_high, .o_mac_low,
    .i_valid, .o_ready, .o_cfg_ready
);
`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for the AES-128 CBC-MAC unit
// A directed table (known vectors, extremes, key change mid-message), a
// back-pressure burst and then random messages are pushed through the block.
// Each MAC item is compared with a local AES-128 model or a typed table MAC.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acm_pkg::*;

    localparam int N_RANDOM   = 1700;
    localparam int SETTLE_CYC = 30;   // a non-last block may still be in the engine

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_block_high;
    logic [63:0] i_block_low;
    logic        i_last_block;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_mac_high;
    logic [63:0] o_mac_low;

    aes128_cbc_mac_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_block_high (i_block_high),
        .i_block_low  (i_block_low),
        .i_last_block (i_last_block),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_mac_high   (o_mac_high),
        .o_mac_low    (o_mac_low)
    );

    // ------------------------------------------------------------------------
    // AES-128 model state
    // ------------------------------------------------------------------------
    logic [7:0] aes_sub [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_mac;

    t_mac         mac_due[$];     // MACs still owed by the block, oldest first
    logic [63:0]  key_hi_m;
    logic [63:0]  key_lo_m;
    logic [127:0] chain_m;
    int           n_err;
    int           hold_left;      // receiver back-pressure stretch, in cycles
    bit           no_idle;        // full-rate stretch on both sides

    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encipher(input logic [127:0] pt,
                                                  input logic [127:0] key);
        logic [7:0] w [176];
        logic [7:0] s [16];
        logic [7:0] n [16];
        logic [7:0] t [4];
        logic [7:0] tmp, rc, a0, a1, a2, a3, al;
        logic [127:0] ct;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            w[i] = key[127-8*i -: 8];
            s[i] = pt[127-8*i -: 8] ^ w[i];
        end
        // key schedule, one word at a time
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) t[j] = w[i-4+j];
            if (i % 16 == 0) begin
                tmp  = t[0];
                t[0] = aes_sub[t[1]] ^ rc;
                t[1] = aes_sub[t[2]];
                t[2] = aes_sub[t[3]];
                t[3] = aes_sub[tmp];
                rc   = gf_dbl(rc);
            end
            for (int j = 0; j < 4; j++) w[i+j] = w[i-16+j] ^ t[j];
        end
        for (int rnd = 1; rnd <= 10; rnd++) begin
            // SubBytes + ShiftRows
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    n[r+4*c] = aes_sub[s[r + 4*((c + r) % 4)]];
            for (int c = 0; c < 4; c++) begin
                a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
                if (rnd < 10) begin
                    al = a0 ^ a1 ^ a2 ^ a3;
                    s[4*c]   = a0 ^ al ^ gf_dbl(a0 ^ a1);
                    s[4*c+1] = a1 ^ al ^ gf_dbl(a1 ^ a2);
                    s[4*c+2] = a2 ^ al ^ gf_dbl(a2 ^ a3);
                    s[4*c+3] = a3 ^ al ^ gf_dbl(a3 ^ a0);
                end else begin
                    s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
                end
            end
            for (int i = 0; i < 16; i++) s[i] ^= w[16*rnd + i];
        end
        for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = s[i];
        return ct;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // MAC receiver: random stalls, a long hold-off on request, and the check
    // ------------------------------------------------------------------------
    initial begin
        t_mac exp_mac;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (mac_due.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("MAC item with none expected: %h_%h", o_mac_high, o_mac_low);
                end else begin
                    exp_mac = mac_due.pop_front();
                    if (o_mac_high !== exp_mac.hi || o_mac_low !== exp_mac.lo) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("MAC mismatch: exp %h_%h got %h_%h",
                                     exp_mac.hi, exp_mac.lo, o_mac_high, o_mac_low);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= no_idle || ($urandom_range(99) >= 27);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Send one block; on acceptance the model advances. A typed MAC replaces
    // the predicted one for rows whose answer is known by heart.
    task automatic send_block(input logic [63:0] bh, input logic [63:0] bl,
                              input bit lst, input bit typed,
                              input logic [63:0] eh, input logic [63:0] el);
        int   gap;
        t_mac m;
        gap = (!no_idle && $urandom_range(99) < 27) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_block_high <= bh;
        i_block_low  <= bl;
        i_last_block <= lst;
        do @(posedge i_clk); while (!o_ready);
        chain_m = aes_encipher(chain_m ^ {bh, bl}, {key_hi_m, key_lo_m});
        if (lst) begin
            m.hi = typed ? eh : chain_m[127:64];
            m.lo = typed ? el : chain_m[63:0];
            mac_due.push_back(m);
            chain_m = '0;
        end
    endtask

    // Key update while the block is idle. which: bit0 high half, bit1 low half.
    task automatic load_key(input logic [63:0] kh, input logic [63:0] kl,
                            input logic [1:0] which);
        i_valid <= 1'b0;
        while (mac_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (which[0]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_KEY_HIGH;
            i_cfg_data  <= kh;
            do @(posedge i_clk); while (!o_cfg_ready);
            key_hi_m = kh;
        end
        if (which[1]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_KEY_LOW;
            i_cfg_data  <= kl;
            do @(posedge i_clk); while (!o_cfg_ready);
            key_lo_m = kl;
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: a key row loads the key, other rows are blocks
    // ------------------------------------------------------------------------
    typedef struct {
        bit          is_key;
        logic [63:0] a;
        logic [63:0] b;
        bit          lst;
        bit          typed;
        logic [63:0] eh;
        logic [63:0] el;
    } t_row;

    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

    t_row plan [] = '{
        // reset key (zero): all-zero block gives AES_0(0)
        '{0, 64'h0, 64'h0, 1, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
        '{0, ONES, ONES, 1, 0, 0, 0},
        // three-block message
        '{0, 64'h0123456789abcdef, 64'hfedcba9876543210, 0, 0, 0, 0},
        '{0, 64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a, 0, 0, 0, 0},
        '{0, 64'h8000000000000000, 64'h0000000000000001, 1, 0, 0, 0},
        // standard AES-128 test vector
        '{1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 0, 0, 0, 0},
        '{0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1, 1, 64'h69c4e0d86a7b0430,
          64'hd8cdb78070b4c55a},
        // key changed in the middle of a message
        '{0, 64'h0, ONES, 0, 0, 0, 0},
        '{1, ONES, ONES, 0, 0, 0, 0},
        '{0, ONES, 64'h0, 1, 0, 0, 0},
        '{0, 64'h0, 64'h0, 1, 0, 0, 0},
        '{0, ONES, ONES, 0, 0, 0, 0},
        '{0, ONES, ONES, 1, 0, 0, 0},
        '{1, 64'h0, 64'h0, 0, 0, 0, 0},
        '{0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1, 0, 0, 0}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int n_sent;
        int len;
        int wait_cyc;
        logic [63:0] kh;
        logic [63:0] kl;

        i_rst_n      <= 1'b0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= REG_KEY_HIGH;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_block_high <= '0;
        i_block_low  <= '0;
        i_last_block <= 1'b0;
        key_hi_m  = '0;
        key_lo_m  = '0;
        chain_m   = '0;
        n_err     = 0;
        hold_left = 0;
        no_idle   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].is_key)
                load_key(plan[k].a, plan[k].b, 2'b11);
            else
                send_block(plan[k].a, plan[k].b, plan[k].lst, plan[k].typed,
                           plan[k].eh, plan[k].el);
        end

        // back-pressure: receiver holds off while single-block MACs pile up
        hold_left = 250;
        repeat (12) send_block(rnd64(), rnd64(), 1'b1, 1'b0, 64'h0, 64'h0);

        // random messages of 1..12 blocks (mostly 1..6), key changes now and then
        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            if ($urandom_range(99) < 3) begin
                case ($urandom_range(3))
                    0: begin kh = '0;  kl = '0;  end
                    1: begin kh = ONES; kl = ONES; end
                    default: begin kh = rnd64(); kl = rnd64(); end
                endcase
                load_key(kh, kl, 2'($urandom_range(1, 3)));
            end
            no_idle = (n_sent >= 700 && n_sent < 950);
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int b = 0; b < len; b++) begin
                send_block(rnd64(), rnd64(), b == len - 1, 1'b0, 64'h0, 64'h0);
                n_sent++;
            end
        end
        i_valid <= 1'b0;
        no_idle = 1'b0;

        wait_cyc = 0;
        while (mac_due.size() != 0 && wait_cyc < 200_000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (n_err == 0 && mac_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### aes128_cbc_mac_unit.f
hw/rtl/acm_pkg.sv
hw/rtl/acm_front.sv
hw/rtl/acm_back.sv
hw/rtl/aes128_cbc_mac_unit.sv
hw/rtl/acm_checker.sv
sim/tb.sv
